>>> design/prog_pkg.sv
// ----------------------------------------------------------------------------
// prog_pkg
// Shared constants, types and helpers of the rebalance order generator.
// ----------------------------------------------------------------------------
`default_nettype none

package prog_pkg;

  localparam int STOCK_COUNT = 4;
  localparam int MAX_STOCKS  = 4;
  localparam int USED_STOCKS = (STOCK_COUNT < 1) ? 1 :
                               ((STOCK_COUNT > MAX_STOCKS) ? MAX_STOCKS : STOCK_COUNT);
  localparam int LANE_W      = (USED_STOCKS > 1) ? $clog2(USED_STOCKS) : 1;
  localparam int MSG_WORDS   = 12;
  localparam int DIV_STEPS   = 48;
  localparam int CFG_IDX_W   = 3;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;
  localparam logic signed [47:0] CASH_RESET = 48'sd100000000;
  localparam logic signed [47:0] CASH_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] CASH_MIN   = 48'sh8000_0000_0000;

  localparam logic [63:0] SYM_RESET_A = 64'd4705572934269108256;
  localparam logic [63:0] SYM_RESET_B = 64'd5354089880436367392;
  localparam logic [63:0] SYM_RESET_C = 64'd4851294584862253088;
  localparam logic [63:0] SYM_RESET_D = 64'd5784012024063909920;

  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_D = 3'd3;

  localparam logic [7:0] CH_O    = 8'h4F;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_Y    = 8'h59;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X    = 8'h58;

  typedef struct packed {
    logic mul_en;
    logic div_start;
    logic commit;
  } lane_ctrl_t;

  typedef struct packed {
    logic val_en;
    logic commit;
  } merge_ctrl_t;

  // clamp a 52-bit signed value into the signed 48-bit range
  function automatic logic signed [47:0] clamp48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v > 52'(CASH_MAX)) r = CASH_MAX;
    else if (v < 52'(CASH_MIN)) r = CASH_MIN;
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic [31:0] msg_word(input logic [3:0] j, input logic [31:0] ref_no,
                                           input logic [7:0] side, input logic [31:0] qty,
                                           input logic [63:0] sym, input logic [31:0] price);
    logic [31:0] w;
    case (j)
      4'd0:    w = {CH_O, ref_no[31:8]};
      4'd1:    w = {ref_no[7:0], side, qty[31:16]};
      4'd2:    w = {qty[15:0], sym[63:48]};
      4'd3:    w = sym[47:16];
      4'd4:    w = {sym[15:0], 16'h0000};
      4'd5:    w = {16'h0000, price[31:16]};
      4'd6:    w = {price[15:0], CH_ZERO, CH_Y};
      4'd7:    w = {CH_P, CH_Y, CH_N, 8'h43};
      4'd8:    w = {8'h4C, CH_O, 8'h52, 8'h44};
      4'd9:    w = {8'h5F, 8'h49, 8'h44, CH_ZERO};
      4'd10:   w = {CH_ZERO, 8'h31, CH_X, CH_X};
      default: w = {CH_X, 24'h000000};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/prog_if.sv
// ----------------------------------------------------------------------------
// prog_if
// Stream channels: price/weight input beats and output word beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface prog_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] price_a;
  logic [31:0] price_b;
  logic [31:0] price_c;
  logic [31:0] price_d;
  logic [16:0] weight_a;
  logic [16:0] weight_b;
  logic [16:0] weight_c;
  logic [16:0] weight_d;
  modport source (output valid, price_a, price_b, price_c, price_d,
                  weight_a, weight_b, weight_c, weight_d, input ready);
  modport sink   (input valid, price_a, price_b, price_c, price_d,
                  weight_a, weight_b, weight_c, weight_d, output ready);
endinterface

interface prog_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        is_order;
  logic        last_word;
  modport source (output valid, out_word, is_order, last_word, input ready);
  modport sink   (input valid, out_word, is_order, last_word, output ready);
endinterface

`default_nettype wire

>>> design/portfolio_rebalance_order_gen.sv
// Each accepted beat gives a value word, then 12*USED_STOCKS order words, one
// word a cycle while the output is not stalled; a new beat is taken only after
// the last order word. Each lane has a 48-step restoring divider.
// Items with a weight above 1.0 are dropped in the check state with no output.
// Reset: holdings zero, cash 10000 dollars, reference 1, symbols to defaults.
// ----------------------------------------------------------------------------
// portfolio_rebalance_order_gen
// Values the portfolio per price beat and streams rebalance order messages.
// ----------------------------------------------------------------------------
`default_nettype none

module portfolio_rebalance_order_gen (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  prog_in_if.sink                         in_i,
  prog_out_if.source                      out_o,
  input  wire                             cfg_we_i,
  input  wire [prog_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [63:0]                      cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_PROD, S_VAL, S_DSTART, S_DWAIT, S_EMIT
  } state_e;

  localparam int U = prog_pkg::USED_STOCKS;

  state_e state_q;
  logic [63:0] sym_q [prog_pkg::MAX_STOCKS];
  logic [31:0] price_q  [prog_pkg::MAX_STOCKS];
  logic [16:0] weight_q [prog_pkg::MAX_STOCKS];
  logic [31:0] ref_q;
  logic        first_q;
  logic [prog_pkg::LANE_W-1:0] lane_q;
  logic [3:0]  j_q;
  logic        ov_q;
  logic [31:0] ow_q;
  logic        oi_q, ol_q;

  prog_pkg::lane_ctrl_t  lctrl;
  prog_pkg::merge_ctrl_t mctrl;
  logic [63:0] prod  [U];
  logic [47:0] cost  [U];
  logic [7:0]  side  [U];
  logic [31:0] qty   [U];
  logic        done  [U];
  logic signed [47:0] value;
  logic [31:0] vword;
  logic        bad;
  logic        emit_go;
  logic        last_lane;

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < U; i++) bad = bad | (weight_q[i] > prog_pkg::WEIGHT_ONE);
  end

  assign lctrl.mul_en    = (state_q == S_PROD);
  assign lctrl.div_start = (state_q == S_DSTART);
  assign lctrl.commit    = (state_q == S_DWAIT) && done[0];
  assign mctrl.val_en    = (state_q == S_VAL);
  assign mctrl.commit    = lctrl.commit;

  for (genvar g = 0; g < U; g++) begin : g_lane
    prog_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lctrl),
      .price_i (price_q[g]),
      .weight_i(weight_q[g]),
      .value_i (value),
      .prod_o  (prod[g]),
      .cost_o  (cost[g]),
      .side_o  (side[g]),
      .qty_o   (qty[g]),
      .done_o  (done[g])
    );
  end

  prog_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctrl),
    .prod_i (prod),
    .cost_i (cost),
    .value_o(value),
    .vword_o(vword)
  );

  assign emit_go   = (state_q == S_EMIT) && (!ov_q || out_o.ready);
  assign last_lane = (32'(lane_q) == 32'(U - 1));
  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sym_q[0] <= prog_pkg::SYM_RESET_A;
      sym_q[1] <= prog_pkg::SYM_RESET_B;
      sym_q[2] <= prog_pkg::SYM_RESET_C;
      sym_q[3] <= prog_pkg::SYM_RESET_D;
      ref_q   <= 32'd1;
      ov_q    <= 1'b0;
      first_q <= 1'b0;
      lane_q  <= '0;
      j_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          prog_pkg::REG_SYMBOL_A: sym_q[0] <= cfg_data_i;
          prog_pkg::REG_SYMBOL_B: sym_q[1] <= cfg_data_i;
          prog_pkg::REG_SYMBOL_C: sym_q[2] <= cfg_data_i;
          prog_pkg::REG_SYMBOL_D: sym_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      if (ov_q && out_o.ready) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            price_q[0]  <= in_i.price_a;
            price_q[1]  <= in_i.price_b;
            price_q[2]  <= in_i.price_c;
            price_q[3]  <= in_i.price_d;
            weight_q[0] <= in_i.weight_a;
            weight_q[1] <= in_i.weight_b;
            weight_q[2] <= in_i.weight_c;
            weight_q[3] <= in_i.weight_d;
            state_q     <= S_CHK;
          end
        end
        S_CHK:    state_q <= bad ? S_IDLE : S_PROD;
        S_PROD:   state_q <= S_VAL;
        S_VAL:    state_q <= S_DSTART;
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (done[0]) begin
            state_q <= S_EMIT;
            first_q <= 1'b1;
            lane_q  <= '0;
            j_q     <= '0;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            ov_q <= 1'b1;
            if (first_q) begin
              ow_q    <= vword;
              oi_q    <= 1'b0;
              ol_q    <= 1'b0;
              first_q <= 1'b0;
            end else begin
              ow_q <= prog_pkg::msg_word(j_q, ref_q + 32'(lane_q), side[lane_q],
                                         qty[lane_q], sym_q[2'(lane_q)],
                                         price_q[2'(lane_q)]);
              oi_q <= 1'b1;
              ol_q <= last_lane && (j_q == 4'(prog_pkg::MSG_WORDS - 1));
              if (j_q == 4'(prog_pkg::MSG_WORDS - 1)) begin
                j_q <= '0;
                if (last_lane) begin
                  ref_q   <= ref_q + 32'(U);
                  state_q <= S_IDLE;
                end else begin
                  lane_q <= lane_q + 1'b1;
                end
              end else begin
                j_q <= j_q + 4'd1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_word  = ow_q;
  assign out_o.is_order  = oi_q;
  assign out_o.last_word = ol_q;

endmodule

`default_nettype wire

>>> design/prog_lane.sv
// ----------------------------------------------------------------------------
// prog_lane
// Per-stock lane: holding value product, target share division, order side.
// ----------------------------------------------------------------------------
`default_nettype none

module prog_lane (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  prog_pkg::lane_ctrl_t    ctrl_i,
  input  wire [31:0]              price_i,
  input  wire [16:0]              weight_i,
  input  wire signed [47:0]       value_i,
  output logic [63:0]             prod_o,
  output logic [47:0]             cost_o,
  output logic [7:0]              side_o,
  output logic [31:0]             qty_o,
  output logic                    done_o
);

  logic [31:0] held_q;
  logic [63:0] prod_q;
  logic [40:0] mlo_q;
  logic [63:0] mulw_q;
  logic [47:0] dvd_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic        mh_q, ld_q, run_q, fin_q, cst_q, done_q, zero_q;
  logic [31:0] target_q;
  logic [47:0] cost_q;
  logic [7:0]  side_q;
  logic [31:0] qty_q;

  logic [46:0] vpos;
  logic [39:0] mhi;
  logic [32:0] rem_sh;
  logic        qbit;
  logic [32:0] rem_nx;
  logic [63:0] cost_full;

  assign vpos   = (value_i > 48'sd0) ? value_i[46:0] : 47'd0;
  assign mhi    = weight_i * vpos[46:24];
  assign rem_sh = {rem_q, dvd_q[47]};
  assign qbit   = (rem_sh >= {1'b0, price_i});
  assign rem_nx = qbit ? (rem_sh - {1'b0, price_i}) : rem_sh;
  assign cost_full = target_q * price_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      mh_q   <= 1'b0;
      ld_q   <= 1'b0;
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      cst_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      mh_q   <= 1'b0;
      ld_q   <= 1'b0;
      fin_q  <= 1'b0;
      cst_q  <= fin_q;
      done_q <= cst_q;
      if (ctrl_i.mul_en) prod_q <= held_q * price_i;
      // weight times value in two halves, the low half registered first
      if (ctrl_i.div_start) begin
        mlo_q  <= weight_i * vpos[23:0];
        zero_q <= (price_i == 32'd0) || !(value_i > 48'sd0);
        mh_q   <= 1'b1;
      end
      if (mh_q) begin
        mulw_q <= {mhi, 24'd0} + {23'd0, mlo_q};
        ld_q   <= 1'b1;
      end
      if (ld_q) begin
        dvd_q <= mulw_q[63:16];
        rem_q <= '0;
        cnt_q <= 6'(prog_pkg::DIV_STEPS);
        run_q <= 1'b1;
      end
      if (run_q) begin
        rem_q <= rem_nx[31:0];
        dvd_q <= {dvd_q[46:0], qbit};
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
      if (fin_q) begin
        if (zero_q) target_q <= '0;
        else if (dvd_q[47:32] != 16'd0) target_q <= '1;
        else target_q <= dvd_q[31:0];
      end
      if (cst_q) begin
        cost_q <= cost_full[47:0];
        if (target_q > held_q) begin
          side_q <= prog_pkg::CH_B;
          qty_q  <= target_q - held_q;
        end else if (target_q < held_q) begin
          side_q <= prog_pkg::CH_S;
          qty_q  <= held_q - target_q;
        end else begin
          side_q <= prog_pkg::CH_N;
          qty_q  <= '0;
        end
      end
      if (ctrl_i.commit) held_q <= target_q;
    end
  end

  assign prod_o = prod_q;
  assign cost_o = cost_q;
  assign side_o = side_q;
  assign qty_o  = qty_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> design/prog_merge.sv
// ----------------------------------------------------------------------------
// prog_merge
// Combines lane results: portfolio value and the cash balance update.
// ----------------------------------------------------------------------------
`default_nettype none

module prog_merge (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  prog_pkg::merge_ctrl_t ctrl_i,
  input  wire [63:0]            prod_i [prog_pkg::USED_STOCKS],
  input  wire [47:0]            cost_i [prog_pkg::USED_STOCKS],
  output logic signed [47:0]    value_o,
  output logic [31:0]           vword_o
);

  logic signed [47:0] cash_q;
  logic signed [47:0] value_q;
  logic [65:0] psum;
  logic [48:0] hv;
  logic [49:0] csum;
  logic signed [51:0] vsum, diff;

  always_comb begin
    psum = '0;
    csum = '0;
    for (int i = 0; i < prog_pkg::USED_STOCKS; i++) begin
      psum = psum + {2'b00, prod_i[i]};
      csum = csum + {2'b00, cost_i[i]};
    end
    // held value saturates at 2^48
    hv   = (psum > 66'h1_0000_0000_0000) ? 49'h1_0000_0000_0000 : psum[48:0];
    vsum = 52'(cash_q) + signed'({3'b000, hv});
    diff = 52'(value_q) - signed'({2'b00, csum});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cash_q <= prog_pkg::CASH_RESET;
    end else begin
      if (ctrl_i.val_en) value_q <= prog_pkg::clamp48(vsum);
      if (ctrl_i.commit) cash_q  <= prog_pkg::clamp48(diff);
    end
  end

  assign value_o = value_q;
  assign vword_o = (value_q <= 48'sd0) ? 32'd0 :
                   ((value_q[47:32] != 16'd0) ? 32'hFFFF_FFFF : value_q[31:0]);

endmodule

`default_nettype wire

>>> design/prog_checker.sv
// ----------------------------------------------------------------------------
// prog_checker
// Port-level checks of the rebalance order generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module prog_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [31:0] out_word_i,
  input wire        is_order_i,
  input wire        last_word_i
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i) && $stable(last_word_i))
    else $error("output beat changed while stalled");

  // final word is always an order word
  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_word_i |-> is_order_i)
    else $error("last_word on value word");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // value word is never the final word, so after it an order word must follow
  a_value_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !is_order_i |=> !in_ready_i)
    else $error("idle right after value word");

endmodule

bind portfolio_rebalance_order_gen prog_checker u_prog_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_word_i (out_o.out_word),
  .is_order_i (out_o.is_order),
  .last_word_i(out_o.last_word)
);

`default_nettype wire
